/* hdl/bloom_filter_double_hash_assert.svh */
// Assertion macros used by the bloom filter top level.
`ifndef BLOOM_FILTER_DOUBLE_HASH_ASSERT_SVH
`define BLOOM_FILTER_DOUBLE_HASH_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define BFDH_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset.
`define BFDH_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define BFDH_ASSERT_NOW(lbl, pre, post, msg)
`define BFDH_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

/* hdl/bfdh_pkg.sv */
// Shared constants and types of the double-hash bloom filter.
package bfdh_pkg;

	// Capacity
	localparam int MAX_BITS   = 4096;
	localparam int MAX_HASHES = 16;

	// Index and modulus widths
	localparam int IDX_W = $clog2(MAX_BITS);
	localparam int M_W   = IDX_W + 1;
	localparam int K_W   = $clog2(MAX_HASHES + 1);

	// Bit store organized as rows
	localparam int ROW_W    = 16;
	localparam int ROW_BITS = $clog2(ROW_W);
	localparam int ROWS     = MAX_BITS / ROW_W;
	localparam int ROW_AW   = $clog2(ROWS);

	// Hash reduction: DIG dividend bits per cycle
	localparam int HASH_W = 64;
	localparam int DIG    = 4;
	localparam int STEPS  = HASH_W / DIG;
	localparam int STEP_W = $clog2(STEPS);

	// Configuration port
	localparam int BC_W       = 13;
	localparam int HC_W       = 5;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 2;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT = 2'd1;
	localparam logic [BC_W-1:0] BIT_COUNT_RST  = 13'd4096;
	localparam logic [HC_W-1:0] HASH_COUNT_RST = 5'd7;

	// Operation codes
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	// Remainders of the two hashes and of 2^64, all modulo the bit count
	typedef struct packed {
		logic [IDX_W-1:0] ra;
		logic [IDX_W-1:0] rb;
		logic [IDX_W-1:0] rc;
	} mod_res_t;

	// One cycle of traffic to the bit store
	typedef struct packed {
		logic [ROW_AW-1:0] raddr;
		logic              we;
		logic [ROW_AW-1:0] waddr;
		logic [ROW_W-1:0]  wdata;
	} mem_req_t;

endpackage

/* hdl/bfdh_if.sv */
// Valid/ready channels for key beats and query result beats.
interface bfdh_in_if import bfdh_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              kind;
	logic [HASH_W-1:0] hash_a;
	logic [HASH_W-1:0] hash_b;

	modport source (output valid, kind, hash_a, hash_b, input ready);
	modport sink (input valid, kind, hash_a, hash_b, output ready);
endinterface

interface bfdh_out_if;
	logic valid;
	logic ready;
	logic present;

	modport source (output valid, present, input ready);
	modport sink (input valid, present, output ready);
endinterface

/* hdl/bfdh_mod_unit.sv */
// Iterative reduction of both hashes and of 2^64 modulo the bit count.
module bfdh_mod_unit import bfdh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [M_W-1:0]    m,
	input  logic [HASH_W-1:0] a,
	input  logic [HASH_W-1:0] b,
	output logic              done,
	output mod_res_t          res
);

	logic [HASH_W-1:0] a_q, b_q;
	logic [IDX_W-1:0]  ra_q, rb_q, rc_q;
	logic [M_W-1:0]    m_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q, done_q;
	logic [IDX_W-1:0]  ra_n, rb_n, rc_n;

	// Shift one dividend bit into a remainder, subtract once if it reaches m
	function automatic logic [IDX_W-1:0] shift_in(input logic [IDX_W-1:0] r,
			input logic bit_in, input logic [M_W-1:0] mod);
		logic [IDX_W:0] t;
		t = {r, bit_in};
		if (t >= mod)
			t = t - mod;
		return t[IDX_W-1:0];
	endfunction

	// Take DIG bits from the top of each dividend in this cycle
	always_comb begin
		ra_n = ra_q;
		rb_n = rb_q;
		rc_n = rc_q;
		for (int d = 0; d < DIG; d++) begin
			ra_n = shift_in(ra_n, a_q[HASH_W-1-d], m_q);
			rb_n = shift_in(rb_n, b_q[HASH_W-1-d], m_q);
			rc_n = shift_in(rc_n, 1'b0, m_q);
		end
	end

	// Control: busy until the last of the STEPS steps, then a done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load on start, advance while busy
	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			b_q  <= b;
			m_q  <= m;
			ra_q <= '0;
			rb_q <= '0;
			// leading one of 2^64, already reduced
			rc_q <= (m == M_W'(1)) ? '0 : IDX_W'(1);
		end else if (busy_q) begin
			a_q  <= a_q << DIG;
			b_q  <= b_q << DIG;
			ra_q <= ra_n;
			rb_q <= rb_n;
			rc_q <= rc_n;
		end
	end

	assign done   = done_q;
	assign res.ra = ra_q;
	assign res.rb = rb_q;
	assign res.rc = rc_q;

endmodule

/* hdl/bfdh_bit_mem.sv */
// Filter bit store: rows of bits, one read and one write port, row valid bits.
module bfdh_bit_mem import bfdh_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  mem_req_t         req,
	output logic [ROW_W-1:0] rdata
);

	logic [ROW_W-1:0] mem [ROWS];
	logic [ROWS-1:0]  row_valid_q;
	logic [ROW_W-1:0] rdata_q;

	// Write the row array
	always_ff @(posedge clk) begin
		if (req.we)
			mem[req.waddr] <= req.wdata;
	end

	// Mark rows written since reset; an unmarked row reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			row_valid_q <= '0;
		else if (req.we)
			row_valid_q[req.waddr] <= 1'b1;
	end

	// Registered read, forward a write to the same row in the same cycle
	always_ff @(posedge clk) begin
		if (req.we && req.waddr == req.raddr)
			rdata_q <= req.wdata;
		else if (row_valid_q[req.raddr])
			rdata_q <= mem[req.raddr];
		else
			rdata_q <= '0;
	end

	assign rdata = rdata_q;

endmodule

/* hdl/bloom_filter_double_hash.sv */
// Top level of the double-hash bloom filter: control, configuration, result register.
// Bloom filter over up to MAX_BITS bits with double hashing. Each key beat carries
// two 64-bit hashes and an insert or query kind; index i is (hash_a + i*hash_b)
// mod 2^64, reduced modulo bit_count. Keys are processed one at a time. The
// remainder unit reduces hash_a, hash_b and 2^64 by the bit count at four bits
// per cycle; the block waits in ST_MOD until its registered done flag. A setup
// state follows. The bit store then takes one row read per derived index, and a
// drain state covers the last write back; with a hash_count of zero both are
// skipped. A query then passes through a result state for its result beat, and
// a new key is accepted only once the block is back in idle. A finished result
// waits in an output register while the next key is accepted. The bit store is
// clear right after reset through per-row valid bits; there is no clearing pass.
// Write bit_count and hash_count only while the block is idle.
`include "bloom_filter_double_hash_assert.svh"
module bloom_filter_double_hash import bfdh_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	bfdh_in_if.sink              in_ch,
	bfdh_out_if.source           out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_MOD    = 6'b000010,
		ST_SETUP  = 6'b000100,
		ST_HASH   = 6'b001000,
		ST_DRAIN  = 6'b010000,
		ST_RESULT = 6'b100000
	} state_t;

	state_t            state_q;
	logic [BC_W-1:0]   bit_count_q;
	logic [HC_W-1:0]   hash_count_q;
	logic [M_W-1:0]    m_used, m_q;
	logic [K_W-1:0]    k_used, k_q, cnt_q;
	logic              kind_q, all_q;
	logic [HASH_W-1:0] s_q, b_q;
	logic [IDX_W-1:0]  r_q, bm_q, t_q;
	logic              v_s1;
	logic [ROW_AW-1:0] row_s1;
	logic [ROW_BITS-1:0] bit_s1;
	logic              out_valid_q, present_q;
	logic              in_acc, mod_done, carry;
	logic [HASH_W-1:0] s_next;
	logic [IDX_W:0]    r_sum, t_full;
	logic [IDX_W-1:0]  r_next;
	logic [ROW_W-1:0]  rdata;
	mod_res_t          mres;
	mem_req_t          mreq;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q  <= BIT_COUNT_RST;
			hash_count_q <= HASH_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BIT_COUNT:  bit_count_q  <= cfg_data[BC_W-1:0];
				REG_HASH_COUNT: hash_count_q <= cfg_data[HC_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the configuration to the capacity
	always_comb begin
		if (bit_count_q == '0)
			m_used = M_W'(1);
		else if (bit_count_q > BC_W'(MAX_BITS))
			m_used = M_W'(MAX_BITS);
		else
			m_used = M_W'(bit_count_q);
		if (hash_count_q > HC_W'(MAX_HASHES))
			k_used = K_W'(MAX_HASHES);
		else
			k_used = K_W'(hash_count_q);
	end

	assign in_acc      = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);

	bfdh_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_acc),
		.m      (m_used),
		.a      (in_ch.hash_a),
		.b      (in_ch.hash_b),
		.done   (mod_done),
		.res    (mres)
	);

	// Step offset when the 64-bit sum wraps: (b - 2^64) mod m
	assign t_full = (mres.rb >= mres.rc) ? {1'b0, mres.rb} - {1'b0, mres.rc}
		: {1'b0, mres.rb} + (m_q - {1'b0, mres.rc});

	// Advance the wrapped sum and its remainder by one step
	assign {carry, s_next} = {1'b0, s_q} + {1'b0, b_q};
	assign r_sum  = {1'b0, r_q} + {1'b0, (carry ? t_q : bm_q)};
	assign r_next = (r_sum >= m_q) ? IDX_W'(r_sum - m_q) : r_sum[IDX_W-1:0];

	// Bit store traffic: read the current index row, write back an insert
	always_comb begin
		mreq.raddr = r_q[IDX_W-1:ROW_BITS];
		mreq.we    = v_s1 && (kind_q == KIND_INSERT);
		mreq.waddr = row_s1;
		mreq.wdata = rdata | (ROW_W'(1) << bit_s1);
	end

	bfdh_bit_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rdata  (rdata)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			all_q       <= 1'b1;
		end else begin
			v_s1 <= (state_q == ST_HASH);
			// load a result beat when the register is free, drop it once taken
			if (state_q == ST_RESULT && (!out_valid_q || out_ch.ready))
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
			// fold the row read in the previous cycle into the query answer
			if (v_s1 && kind_q == KIND_QUERY)
				all_q <= all_q & rdata[bit_s1];
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc)
						state_q <= ST_MOD;
				end
				ST_MOD: begin
					if (mod_done)
						state_q <= ST_SETUP;
				end
				ST_SETUP: begin
					cnt_q <= '0;
					all_q <= 1'b1;
					if (k_q != '0)
						state_q <= ST_HASH;
					else if (kind_q == KIND_QUERY)
						state_q <= ST_RESULT;
					else
						state_q <= ST_IDLE;
				end
				ST_HASH: begin
					cnt_q <= cnt_q + 1'b1;
					if (K_W'(cnt_q + 1'b1) == k_q)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					state_q <= (kind_q == KIND_QUERY) ? ST_RESULT : ST_IDLE;
				end
				ST_RESULT: begin
					// hold until the output register is free
					if (!out_valid_q || out_ch.ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q <= in_ch.kind;
			s_q    <= in_ch.hash_a;
			b_q    <= in_ch.hash_b;
			m_q    <= m_used;
			k_q    <= k_used;
		end
		if (state_q == ST_SETUP) begin
			r_q  <= mres.ra;
			bm_q <= mres.rb;
			t_q  <= t_full[IDX_W-1:0];
		end
		if (state_q == ST_HASH) begin
			s_q <= s_next;
			r_q <= r_next;
		end
		row_s1 <= r_q[IDX_W-1:ROW_BITS];
		bit_s1 <= r_q[ROW_BITS-1:0];
		if (state_q == ST_RESULT && (!out_valid_q || out_ch.ready))
			present_q <= all_q;
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.present = present_q;

	`BFDH_ASSERT_NEXT(a_accept_starts, in_acc, state_q == ST_MOD, "accepted key did not start reduction")
	`BFDH_ASSERT_NOW(a_cnt_bound, state_q == ST_HASH, cnt_q < k_q, "hash counter passed hash count")
	`BFDH_ASSERT_NOW(a_rem_bound, state_q == ST_HASH, {1'b0, r_q} < m_q, "index remainder not below bit count")
	`BFDH_ASSERT_NOW(a_write_insert, mreq.we, kind_q == KIND_INSERT, "bit store written by a query")

endmodule

/* dv/tb_bloom_filter_double_hash.sv */
// Testbench for the double-hash bloom filter: directed corners, random traffic, self-checking.
module tb_bloom_filter_double_hash import bfdh_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// Register indexes that the block does not decode
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	// Cycles to let an insert finish once no result is pending, with padding
	localparam int SETTLE_CYCLES = 60;
	localparam int TIMEOUT_NS    = 1_000_000;
	localparam int POOL_DEPTH    = 64;

	typedef struct {
		logic [HASH_W-1:0] a;
		logic [HASH_W-1:0] b;
	} key_hashes_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bfdh_in_if  key_ch ();
	bfdh_out_if res_ch ();

	bloom_filter_double_hash DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (key_ch),
		.out_ch    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the filter and its settings
	bit                held_bits [MAX_BITS];
	logic [BC_W-1:0]   bit_count_set;
	logic [HC_W-1:0]   hash_count_set;
	bit                present_due [$];
	key_hashes_t       inserted_keys [$];

	int sender_idle_pct;
	int receiver_idle_pct;
	int mismatches;
	int results_checked;
	int queries_sent;
	int inserts_sent;
	int cfg_writes;

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Abort a hung run
	initial begin
		#(TIMEOUT_NS);
		$display("tb_bloom_filter_double_hash: FAIL");
		$finish;
	end

	// Stall the result channel at random
	always @(posedge clk) begin
		res_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] ERROR %s", $realtime, msg);
		mismatches++;
	endtask

	// Compare each result beat with the oldest pending answer
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (present_due.size() == 0) begin
				report_mismatch($sformatf("result beat present=%0b with no query pending",
					res_ch.present));
			end else begin
				if (res_ch.present !== present_due[0])
					report_mismatch($sformatf("present: expected %0b got %0b",
						present_due[0], res_ch.present));
				void'(present_due.pop_front());
				results_checked++;
			end
		end
	end

	// Set the derived bits of a key, or test them; returns the query answer
	function automatic bit mark_or_probe(input logic kind, input logic [HASH_W-1:0] a,
			input logic [HASH_W-1:0] b);
		logic [HASH_W-1:0] modulus;
		logic [HASH_W-1:0] step;
		logic [HASH_W-1:0] pos;
		int                hashes;
		bit                all_set;
		if (bit_count_set == 0)
			modulus = HASH_W'(1);
		else if (bit_count_set > MAX_BITS)
			modulus = HASH_W'(MAX_BITS);
		else
			modulus = HASH_W'(bit_count_set);
		hashes = (hash_count_set > MAX_HASHES) ? MAX_HASHES : int'(hash_count_set);
		all_set = 1'b1;
		for (int i = 0; i < hashes; i++) begin
			step = HASH_W'(i);
			pos = (a + step * b) % modulus;
			if (kind == KIND_INSERT)
				held_bits[pos[IDX_W-1:0]] = 1'b1;
			else if (!held_bits[pos[IDX_W-1:0]])
				all_set = 1'b0;
		end
		return all_set;
	endfunction

	// Present one key beat, idling first at the sender's rate
	task automatic send_key(input logic kind, input logic [HASH_W-1:0] a,
			input logic [HASH_W-1:0] b);
		bit answer;
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			key_ch.valid <= 1'b0;
			@(posedge clk);
		end
		key_ch.valid  <= 1'b1;
		key_ch.kind   <= kind;
		key_ch.hash_a <= a;
		key_ch.hash_b <= b;
		do @(posedge clk); while (!key_ch.ready);
		answer = mark_or_probe(kind, a, b);
		if (kind == KIND_QUERY) begin
			present_due = {present_due, answer};
			queries_sent++;
		end else begin
			inserts_sent++;
		end
	endtask

	// Drop valid, wait for every pending answer, then let a trailing insert finish
	task automatic settle_idle();
		key_ch.valid <= 1'b0;
		while (present_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_BIT_COUNT)
			bit_count_set = data[BC_W-1:0];
		else if (idx == REG_HASH_COUNT)
			hash_count_set = data[HC_W-1:0];
		cfg_writes++;
		@(posedge clk);
	endtask

	function automatic logic [HASH_W-1:0] pick_hash();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return HASH_W'($urandom_range(0, 15));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Empty filter at reset settings, then the hash extremes
	task automatic test_reset_state();
		send_key(KIND_QUERY, '0, '0);
		send_key(KIND_QUERY, '1, '1);
		send_key(KIND_INSERT, '0, '0);
		send_key(KIND_QUERY, '0, '0);
		send_key(KIND_INSERT, '1, '1);
		send_key(KIND_QUERY, '1, '1);
		send_key(KIND_QUERY, '1, 64'd1);
		send_key(KIND_INSERT, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
		send_key(KIND_QUERY, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
		settle_idle();
	endtask

	// Zero and saturating counts, unknown indexes, reconfiguring a filled store
	task automatic test_config_corners();
		logic [HASH_W-1:0] ka;
		logic [HASH_W-1:0] kb;
		ka = {$urandom, $urandom};
		kb = {$urandom, $urandom};
		// no hashes: every query answers present
		cfg_write(REG_HASH_COUNT, 13'd0);
		send_key(KIND_QUERY, {$urandom, $urandom}, {$urandom, $urandom});
		send_key(KIND_INSERT, ka, kb);
		send_key(KIND_QUERY, {$urandom, $urandom}, {$urandom, $urandom});
		settle_idle();
		// both counts above capacity saturate
		cfg_write(REG_HASH_COUNT, 13'h1FFF);
		cfg_write(REG_BIT_COUNT, 13'h1FFF);
		send_key(KIND_INSERT, ka, kb);
		send_key(KIND_QUERY, ka, kb);
		send_key(KIND_QUERY, {$urandom, $urandom}, {$urandom, $urandom});
		settle_idle();
		// writes to undecoded indexes change nothing
		cfg_write(REG_SPARE_2, 13'd3);
		cfg_write(REG_SPARE_3, 13'h1FFF);
		send_key(KIND_QUERY, ka, kb);
		settle_idle();
		// zero bit count maps every index to bit zero
		cfg_write(REG_BIT_COUNT, 13'd0);
		cfg_write(REG_HASH_COUNT, 13'd1);
		send_key(KIND_QUERY, {$urandom, $urandom}, {$urandom, $urandom});
		send_key(KIND_INSERT, {$urandom, $urandom}, {$urandom, $urandom});
		settle_idle();
		// back to reset settings: earlier inserts are still set
		cfg_write(REG_BIT_COUNT, BIT_COUNT_RST);
		cfg_write(REG_HASH_COUNT, 13'(HASH_COUNT_RST));
		send_key(KIND_QUERY, '1, '1);
		settle_idle();
	endtask

	// One setting, then a mix of fresh keys and replays of inserted ones
	task automatic random_segment(input logic [CFG_DATA_W-1:0] bc,
			input logic [CFG_DATA_W-1:0] hc, input int n_keys);
		key_hashes_t key;
		logic        kind;
		settle_idle();
		cfg_write(REG_BIT_COUNT, bc);
		cfg_write(REG_HASH_COUNT, hc);
		for (int n = 0; n < n_keys; n++) begin
			kind = 1'($urandom_range(0, 1));
			if (kind == KIND_QUERY && inserted_keys.size() != 0 && $urandom_range(0, 1)) begin
				key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
			end else begin
				key.a = pick_hash();
				key.b = pick_hash();
			end
			if (kind == KIND_INSERT) begin
				inserted_keys = {inserted_keys, key};
				if (inserted_keys.size() > POOL_DEPTH)
					void'(inserted_keys.pop_front());
			end
			send_key(kind, key.a, key.b);
		end
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct,
			input logic [CFG_DATA_W-1:0] bc [4], input logic [CFG_DATA_W-1:0] hc [4]);
		sender_idle_pct   = send_pct;
		receiver_idle_pct = recv_pct;
		for (int s = 0; s < 4; s++)
			random_segment(bc[s], hc[s], 40);
		settle_idle();
	endtask

	// Sequence the tests
	initial begin
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= REG_BIT_COUNT;
		cfg_data      <= '0;
		key_ch.valid  <= 1'b0;
		key_ch.kind   <= KIND_INSERT;
		key_ch.hash_a <= '0;
		key_ch.hash_b <= '0;
		sender_idle_pct   = 0;
		receiver_idle_pct = 0;
		bit_count_set  = BIT_COUNT_RST;
		hash_count_set = HASH_COUNT_RST;
		foreach (held_bits[i])
			held_bits[i] = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_config_corners();
		test_random_traffic(33, 70, '{13'd4096, 13'd1, 13'h1FFF, 13'd13},
			'{13'd7, 13'd3, 13'h1FFF, 13'd5});
		test_random_traffic(70, 33, '{13'd4096, 13'd0, 13'd100,
			13'($urandom_range(0, 8191))},
			'{13'd16, 13'd0, 13'd2, 13'($urandom_range(0, 8191))});
		test_random_traffic(0, 0, '{13'd4097, 13'd2048, 13'($urandom_range(0, 8191)),
			13'd4096}, '{13'd1, 13'd16, 13'($urandom_range(0, 8191)), 13'd7});

		$display("covered %0d inserts and %0d queries over %0d register writes",
			inserts_sent, queries_sent, cfg_writes);
		$display("checked %0d result beats, %0d mismatches", results_checked, mismatches);
		if (mismatches == 0)
			$display("tb_bloom_filter_double_hash: PASS");
		else
			$display("tb_bloom_filter_double_hash: FAIL");
		$finish;
	end

endmodule
